// ===== hdl/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// maf_pkg
// shared constants and the controller state type of the max flow unit
// ----------------------------------------------------------------------------
`default_nettype none
package maf_pkg;

	localparam int NODE_BITS = 4;
	localparam int NODES     = 16;
	localparam int MAX_EDGES = 32;
	localparam int EIDX_BITS = 5;
	localparam int ECNT_BITS = 6;
	localparam int CAP_BITS  = 16;
	localparam int FLOW_BITS = 20;
	localparam int RES_DEPTH = NODES * NODES;
	localparam int RES_ABITS = 2 * NODE_BITS;
	localparam int EL_WIDTH  = 2 * NODE_BITS;
	localparam int PADDR_BITS = 3;

	localparam logic [FLOW_BITS-1:0] FLOW_MAX = '1;
	localparam logic [NODE_BITS-1:0] SRC_NODE = NODE_BITS'(1);
	localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(NODES - 1);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN  = 1'b1;
	localparam logic RES_TOTAL = 1'b0;
	localparam logic RES_EDGE  = 1'b1;

	localparam logic [PADDR_BITS-1:0] ADDR_NODE_COUNT = '0;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LOAD2,
		ST_BFS_INIT,
		ST_BFS_POP,
		ST_BFS_RD,
		ST_BFS_CHK,
		ST_AUG_RD,
		ST_AUG_MIN,
		ST_UPD_RD,
		ST_UPD_WF,
		ST_UPD_WB,
		ST_OUT_TOT,
		ST_EMIT_TOT,
		ST_SC_RD,
		ST_SC_CHK,
		ST_SC_FLOW,
		ST_EMIT_EDGE,
		ST_SC_NEXT,
		ST_CLR
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/maf_ram.sv =====
// ----------------------------------------------------------------------------
// maf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module maf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/max_flow_augmenting_path_unit.sv =====
// ----------------------------------------------------------------------------
// max_flow_augmenting_path_unit
// shortest augmenting path max flow over a residual matrix held in ram
//
//  channel  direction  fields
//  in       request    kind, from_node, to_node, capacity
//  out      result     result_kind, edge_from, edge_to, flow_value, last
//  apb      config     node_count at byte address 0
//
// an edge load makes two writes into the one write port of the matrix
// a run scans the neighbors of each popped node in the search, walks the path hop by hop
// for the bottleneck and again for the update, then reads every edge once per
// source node for the report (16 passes over the edge list ram)
// reset and the end of every run clear the matrix at once through per-entry valid bits
// out stall holds the report; requests are taken only while no run or load is in progress
// ----------------------------------------------------------------------------
`default_nettype none
module max_flow_augmenting_path_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [maf_pkg::PADDR_BITS-1:0]    paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              kind,
	input  wire logic [maf_pkg::NODE_BITS-1:0]     from_node,
	input  wire logic [maf_pkg::NODE_BITS-1:0]     to_node,
	input  wire logic [maf_pkg::CAP_BITS-1:0]      capacity,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   result_kind,
	output logic      [maf_pkg::NODE_BITS-1:0]     edge_from,
	output logic      [maf_pkg::NODE_BITS-1:0]     edge_to,
	output logic      [maf_pkg::FLOW_BITS-1:0]     flow_value,
	output logic                                   last
);
	import maf_pkg::*;

	state_t state_q, state_d;

	logic [NODE_BITS-1:0] node_count_q;
	logic [NODE_BITS-1:0] sink_q;
	logic [ECNT_BITS-1:0] ecount_q;
	logic [ECNT_BITS-1:0] nemit_q;
	logic [CAP_BITS-1:0]  maxcap_q;
	logic [FLOW_BITS-1:0] total_q;
	logic [CAP_BITS-1:0]  amount_q;
	logic [NODE_BITS-1:0] ld_from_q, ld_to_q;

	logic [RES_DEPTH-1:0] rvalid_q;
	logic                 vld_s1;

	logic [NODES-1:0]     visited_q;
	logic [NODE_BITS-1:0] parent_q [NODES];
	logic [NODE_BITS-1:0] queue_q [NODES];
	logic [NODE_BITS:0]   head_q, tail_q;
	logic [NODE_BITS-1:0] x_q, y_q, t_q;

	logic [NODE_BITS-1:0] u_q;
	logic [EIDX_BITS-1:0] k_q;
	logic [NODE_BITS-1:0] ef_q, et_q;

	logic                 out_valid_q;
	logic                 out_kind_q, out_last_q;
	logic [NODE_BITS-1:0] out_from_q, out_to_q;
	logic [FLOW_BITS-1:0] out_flow_q;

	logic                 res_we;
	logic [RES_ABITS-1:0] res_waddr, res_raddr;
	logic [CAP_BITS-1:0]  res_wdata, res_rdata;
	logic                 el_we;
	logic [EIDX_BITS-1:0] el_waddr, el_raddr;
	logic [EL_WIDTH-1:0]  el_wdata, el_rdata;

	logic                 in_acc, out_acc, cfg_wr;
	logic [CAP_BITS-1:0]  rd;
	logic [NODE_BITS-1:0] par_t;
	logic [NODE_BITS-1:0] el_from, el_to;
	logic [FLOW_BITS:0]   total_sum;
	logic                 more_edges;

	maf_ram #(.WIDTH(CAP_BITS), .DEPTH(RES_DEPTH)) u_res_ram (
		.clk   (clk),
		.we    (res_we),
		.waddr (res_waddr),
		.wdata (res_wdata),
		.raddr (res_raddr),
		.rdata (res_rdata)
	);

	maf_ram #(.WIDTH(EL_WIDTH), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (el_we),
		.waddr (el_waddr),
		.wdata (el_wdata),
		.raddr (el_raddr),
		.rdata (el_rdata)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign cfg_wr    = psel && penable && pwrite && (paddr == ADDR_NODE_COUNT);
	assign pready    = 1'b1;
	assign prdata    = (paddr == ADDR_NODE_COUNT) ? {(32-NODE_BITS)'(0), node_count_q} : '0;

	assign rd        = vld_s1 ? res_rdata : '0;
	assign par_t     = parent_q[t_q];
	assign el_from   = el_rdata[EL_WIDTH-1:NODE_BITS];
	assign el_to     = el_rdata[NODE_BITS-1:0];
	assign total_sum = {1'b0, total_q} + (FLOW_BITS+1)'(amount_q);
	assign more_edges = (ECNT_BITS'(k_q) + ECNT_BITS'(1)) < ecount_q;

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign edge_from   = out_from_q;
	assign edge_to     = out_to_q;
	assign flow_value  = out_flow_q;
	assign last        = out_last_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (kind == KIND_RUN) begin
						state_d = (node_count_q < NODE_BITS'(2)) ? ST_OUT_TOT : ST_BFS_INIT;
					end else if (ecount_q < ECNT_BITS'(MAX_EDGES)) begin
						state_d = ST_LOAD2;
					end
				end
			end
			ST_LOAD2:    state_d = ST_IDLE;
			ST_BFS_INIT: state_d = ST_BFS_POP;
			ST_BFS_POP:  state_d = (head_q < tail_q) ? ST_BFS_RD : ST_OUT_TOT;
			ST_BFS_RD:   state_d = ST_BFS_CHK;
			ST_BFS_CHK: begin
				if (!visited_q[y_q] && rd != '0 && y_q == sink_q) begin
					state_d = ST_AUG_RD;
				end else if (y_q == sink_q) begin
					state_d = ST_BFS_POP;
				end else begin
					state_d = ST_BFS_RD;
				end
			end
			ST_AUG_RD:   state_d = ST_AUG_MIN;
			ST_AUG_MIN:  state_d = (par_t == SRC_NODE) ? ST_UPD_RD : ST_AUG_RD;
			ST_UPD_RD:   state_d = ST_UPD_WF;
			ST_UPD_WF:   state_d = ST_UPD_WB;
			ST_UPD_WB:   state_d = (par_t == SRC_NODE) ? ST_BFS_INIT : ST_UPD_RD;
			ST_OUT_TOT:  state_d = ST_EMIT_TOT;
			ST_EMIT_TOT: begin
				if (out_acc) begin
					state_d = (ecount_q == '0) ? ST_CLR : ST_SC_RD;
				end
			end
			ST_SC_RD:    state_d = ST_SC_CHK;
			ST_SC_CHK:   state_d = (el_from == u_q) ? ST_SC_FLOW : ST_SC_NEXT;
			ST_SC_FLOW:  state_d = ST_EMIT_EDGE;
			ST_EMIT_EDGE: begin
				if (out_acc) begin
					state_d = ST_SC_NEXT;
				end
			end
			ST_SC_NEXT: begin
				if (!more_edges && u_q == LAST_NODE) begin
					state_d = ST_CLR;
				end else begin
					state_d = ST_SC_RD;
				end
			end
			ST_CLR:      state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		res_we    = 1'b0;
		res_waddr = '0;
		res_wdata = '0;
		res_raddr = '0;
		el_we     = 1'b0;
		el_waddr  = ecount_q[EIDX_BITS-1:0];
		el_wdata  = {from_node, to_node};
		el_raddr  = k_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && kind == KIND_LOAD && ecount_q < ECNT_BITS'(MAX_EDGES)) begin
					res_we    = 1'b1;
					res_waddr = {from_node, to_node};
					res_wdata = capacity;
					el_we     = 1'b1;
				end
			end
			ST_LOAD2: begin
				res_we    = 1'b1;
				res_waddr = {ld_to_q, ld_from_q};
			end
			ST_BFS_RD: res_raddr = {x_q, y_q};
			ST_AUG_RD: res_raddr = {par_t, t_q};
			ST_UPD_RD: res_raddr = {par_t, t_q};
			ST_UPD_WF: begin
				res_we    = 1'b1;
				res_waddr = {par_t, t_q};
				res_wdata = rd - amount_q;
				res_raddr = {t_q, par_t};
			end
			ST_UPD_WB: begin
				res_we    = 1'b1;
				res_waddr = {t_q, par_t};
				res_wdata = rd + amount_q;
			end
			ST_SC_CHK: res_raddr = {el_to, el_from};
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NODE_BITS'(15);
			ecount_q     <= '0;
			maxcap_q     <= '0;
			total_q      <= '0;
			rvalid_q     <= '0;
			visited_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				node_count_q <= pwdata[NODE_BITS-1:0];
			end
			if (res_we) begin
				rvalid_q[res_waddr] <= 1'b1;
			end
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && kind == KIND_LOAD && ecount_q < ECNT_BITS'(MAX_EDGES)) begin
						ecount_q <= ecount_q + ECNT_BITS'(1);
						if (capacity > maxcap_q) begin
							maxcap_q <= capacity;
						end
					end
				end
				ST_BFS_INIT: visited_q <= NODES'(1) << SRC_NODE;
				ST_BFS_CHK: begin
					if (!visited_q[y_q] && rd != '0) begin
						visited_q[y_q] <= 1'b1;
					end
				end
				ST_UPD_WB: begin
					if (par_t == SRC_NODE) begin
						total_q <= (total_sum > (FLOW_BITS+1)'(FLOW_MAX)) ? FLOW_MAX :
							total_sum[FLOW_BITS-1:0];
					end
				end
				ST_OUT_TOT: out_valid_q <= 1'b1;
				ST_SC_FLOW: out_valid_q <= 1'b1;
				ST_CLR: begin
					rvalid_q  <= '0;
					ecount_q  <= '0;
					maxcap_q  <= '0;
					total_q   <= '0;
					visited_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// search, path and report datapath
	always_ff @(posedge clk) begin
		vld_s1 <= rvalid_q[res_raddr];
		case (state_q)
			ST_IDLE: begin
				ld_from_q <= from_node;
				ld_to_q   <= to_node;
				sink_q    <= node_count_q;
			end
			ST_BFS_INIT: begin
				for (int i = 0; i < NODES; i++) begin
					parent_q[i] <= '0;
				end
				queue_q[0] <= SRC_NODE;
				head_q     <= '0;
				tail_q     <= (NODE_BITS+1)'(1);
			end
			ST_BFS_POP: begin
				x_q    <= queue_q[head_q[NODE_BITS-1:0]];
				head_q <= head_q + (NODE_BITS+1)'(1);
				y_q    <= SRC_NODE;
			end
			ST_BFS_CHK: begin
				if (!visited_q[y_q] && rd != '0) begin
					parent_q[y_q] <= x_q;
					if (y_q != sink_q && tail_q < (NODE_BITS+1)'(NODES)) begin
						queue_q[tail_q[NODE_BITS-1:0]] <= y_q;
						tail_q <= tail_q + (NODE_BITS+1)'(1);
					end
				end
				y_q      <= y_q + NODE_BITS'(1);
				t_q      <= sink_q;
				amount_q <= maxcap_q;
			end
			ST_AUG_MIN: begin
				if (rd < amount_q) begin
					amount_q <= rd;
				end
				t_q <= (par_t == SRC_NODE) ? sink_q : par_t;
			end
			ST_UPD_WB: t_q <= par_t;
			ST_OUT_TOT: begin
				out_kind_q <= RES_TOTAL;
				out_from_q <= '0;
				out_to_q   <= '0;
				out_flow_q <= total_q;
				out_last_q <= (ecount_q == '0);
				u_q        <= '0;
				k_q        <= '0;
				nemit_q    <= '0;
			end
			ST_SC_CHK: begin
				ef_q <= el_from;
				et_q <= el_to;
			end
			ST_SC_FLOW: begin
				out_kind_q <= RES_EDGE;
				out_from_q <= ef_q;
				out_to_q   <= et_q;
				out_flow_q <= FLOW_BITS'(rd);
				out_last_q <= (nemit_q + ECNT_BITS'(1) == ecount_q);
				nemit_q    <= nemit_q + ECNT_BITS'(1);
			end
			ST_SC_NEXT: begin
				if (more_edges) begin
					k_q <= k_q + EIDX_BITS'(1);
				end else begin
					k_q <= '0;
					u_q <= u_q + NODE_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == ST_EMIT_TOT || state_q == ST_EMIT_EDGE))
		else $error("result shown outside an emit state");

	a_ecount_max: assert property (@(posedge clk) disable iff (!arst_n)
		ecount_q <= ECNT_BITS'(MAX_EDGES))
		else $error("edge count beyond capacity");

	a_path_positive: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AUG_MIN |-> rd != '0)
		else $error("augmenting path holds an empty edge");

	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == RES_TOTAL) |-> (out_last_q == (ecount_q == '0)))
		else $error("total result last flag wrong");

	a_no_request_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BFS_CHK) |=> in_stall)
		else $error("request taken during search");

endmodule
`default_nettype wire
